[hdl/kmp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmp_pkg
// Shared constants and types of the streaming pattern matcher.
// ----------------------------------------------------------------------------
package kmp_pkg;

    // pattern capacity and text position width
    localparam int PATTERN_MAX   = 128;
    localparam int POSITION_BITS = 24;

    // derived widths
    localparam int BYTE_BITS = 8;
    localparam int LEN_BITS  = $clog2(PATTERN_MAX + 1);

    // item modes
    localparam logic MODE_PATTERN = 1'b0;
    localparam logic MODE_TEXT    = 1'b1;

    // input item
    typedef struct packed {
        logic                 mode;
        logic [BYTE_BITS-1:0] byte_value;
        logic                 restart;
    } in_item_t;

    // result item
    typedef struct packed {
        logic                     match_found;
        logic [POSITION_BITS-1:0] match_start;
        logic [POSITION_BITS-1:0] match_total;
    } out_item_t;

    // broadcast control from the top level to every cell
    typedef struct packed {
        logic                 load;
        logic                 search;
        logic                 flush;
        logic [BYTE_BITS-1:0] data;
    } cell_ctrl_t;

endpackage

[hdl/kmp_stream_matcher.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmp_stream_matcher
// Streaming exact string matcher. Pattern bytes load into a row of cells,
// text bytes are compared against all cells at once and give one result.
//
//   channel  dir  handshake          payload
//   s_       in   s_valid / s_ready  in_item_t  (mode, byte_value, restart)
//   m_       out  m_valid / m_ready  out_item_t (match_found, match_start,
//                                               match_total)
//
// The cell row updates at the input transfer and a text result sits in the
// output register the cycle after.
// A pattern byte gives no result; a text byte gives exactly one.
// Input is held off only while a result waits in the output register and
// m_ready is low. Reset (aresetn low, synchronous) empties the pattern,
// the match state and the counters; pattern bytes themselves are not cleared.
// ----------------------------------------------------------------------------
module kmp_stream_matcher (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  kmp_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output kmp_pkg::out_item_t m_data
);
    import kmp_pkg::*;

    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

    logic                     s_xfer;
    logic                     search;
    logic                     load;
    logic                     found;
    cell_ctrl_t               ctrl;

    logic [LEN_BITS-1:0]      len_reg, len_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [POSITION_BITS-1:0] total_reg, total_next;
    logic                     m_valid_reg, m_valid_next;
    out_item_t                m_data_reg, m_data_next;

    logic [POSITION_BITS-1:0] pos_cur;
    logic [POSITION_BITS-1:0] total_cur;

    // input transfer and decode
    assign s_ready = ~m_valid_reg | m_ready;
    assign s_xfer  = s_valid & s_ready;
    assign search  = s_xfer & (s_data.mode == MODE_TEXT);
    assign load    = s_xfer & (s_data.mode == MODE_PATTERN) &
                     (s_data.restart | (len_reg < LEN_BITS'(PATTERN_MAX)));

    always_comb begin
        ctrl.load   = load;
        ctrl.search = search;
        ctrl.flush  = s_data.restart;
        ctrl.data   = s_data.byte_value;
    end

    kmp_cell_row u_row (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .len_i   (len_reg),
        .found_o (found)
    );

    // pattern length, text position, match total and result register
    always_comb begin
        len_next     = len_reg;
        pos_next     = pos_reg;
        total_next   = total_reg;
        m_valid_next = m_valid_reg & ~m_ready;
        m_data_next  = m_data_reg;
        pos_cur      = s_data.restart ? '0 : pos_reg;
        total_cur    = s_data.restart ? '0 : total_reg;

        if (load) begin
            len_next = s_data.restart ? LEN_BITS'(1) : len_reg + LEN_BITS'(1);
        end

        if (search) begin
            pos_next   = pos_cur + POSITION_BITS'(1);
            total_next = total_cur;
            if (found && total_cur != POS_MAX) begin
                total_next = total_cur + POSITION_BITS'(1);
            end
            m_valid_next            = 1'b1;
            m_data_next.match_found = found;
            m_data_next.match_start = found ?
                (pos_cur + POSITION_BITS'(1) - POSITION_BITS'(len_reg)) : '0;
            m_data_next.match_total = total_next;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg     <= '0;
            pos_reg     <= '0;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            len_reg     <= len_next;
            pos_reg     <= pos_next;
            total_reg   <= total_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // an empty pattern never matches
    a_no_empty_match: assert property (@(posedge aclk) disable iff (!aresetn)
        (search && found) |-> (len_reg != '0))
        else $error("match reported with empty pattern");

    // a text transfer always leaves a result behind
    a_text_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        search |=> m_valid_reg)
        else $error("text byte produced no result");

    // a reported match is counted
    a_match_counted: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.match_found) |-> (m_data_reg.match_total != '0))
        else $error("match not counted in total");

    // pattern length stays within the row
    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= LEN_BITS'(PATTERN_MAX))
        else $error("pattern length beyond capacity");

endmodule

[hdl/kmp_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmp_cell
// One cell of the matcher row: holds one pattern byte and the flag telling
// that the pattern prefix ending at this byte matches the recent text.
// ----------------------------------------------------------------------------
module kmp_cell (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  kmp_pkg::cell_ctrl_t           ctrl,
    input  logic                          head_i,
    input  logic                          in_use_i,
    input  logic [kmp_pkg::BYTE_BITS-1:0] byte_prev_i,
    input  logic                          match_prev_i,
    input  logic                          carry_i,
    output logic [kmp_pkg::BYTE_BITS-1:0] byte_o,
    output logic                          match_o,
    output logic                          hit_o
);
    import kmp_pkg::*;

    logic [BYTE_BITS-1:0] byte_reg;
    logic                 match_reg;
    logic                 match_next;

    // prefix extends through this cell when the text byte equals ours
    assign hit_o = in_use_i & carry_i & (byte_reg == ctrl.data);

    // next match flag: shift on pattern growth, update on text byte
    always_comb begin
        match_next = match_reg;
        if (ctrl.load) begin
            match_next = match_prev_i & ~ctrl.flush;
        end else if (ctrl.search) begin
            // a full match at the head is not kept, the state falls back
            match_next = hit_o & ~head_i;
        end
    end

    // match flag register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_reg <= 1'b0;
        end else begin
            match_reg <= match_next;
        end
    end

    // pattern byte shifts in on each load, from the neighbor or, at cell 0, from the input byte
    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            byte_reg <= byte_prev_i;
        end
    end

    assign byte_o  = byte_reg;
    assign match_o = match_reg;

endmodule

[hdl/kmp_cell_row.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmp_cell_row
// Row of matcher cells. Cell 0 holds the newest pattern byte, so a full
// match always shows at cell 0; cell len-1 holds the first pattern byte.
// ----------------------------------------------------------------------------
module kmp_cell_row (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  kmp_pkg::cell_ctrl_t          ctrl,
    input  logic [kmp_pkg::LEN_BITS-1:0] len_i,
    output logic                         found_o
);
    import kmp_pkg::*;

    logic [BYTE_BITS-1:0] byte_w  [PATTERN_MAX];
    logic                 match_w [PATTERN_MAX];
    logic                 hit_w   [PATTERN_MAX];
    logic                 use_w   [PATTERN_MAX];
    logic                 carry_w [PATTERN_MAX];

    genvar c;
    generate
        for (c = 0; c < PATTERN_MAX; c++) begin : g_cell
            // cell is part of the current pattern
            assign use_w[c] = (LEN_BITS'(c) < len_i);

            // prefix flag from the cell holding the previous pattern byte;
            // the cell of the first pattern byte always starts a prefix
            if (c == PATTERN_MAX - 1) begin : g_tail
                assign carry_w[c] = 1'b1;
            end else begin : g_body
                assign carry_w[c] = (LEN_BITS'(c + 1) < len_i) ?
                                    (match_w[c + 1] & ~ctrl.flush) : 1'b1;
            end

            if (c == 0) begin : g_head
                kmp_cell u_cell (
                    .aclk         (aclk),
                    .aresetn      (aresetn),
                    .ctrl         (ctrl),
                    .head_i       (1'b1),
                    .in_use_i     (use_w[c]),
                    .byte_prev_i  (ctrl.data),
                    .match_prev_i (1'b0),
                    .carry_i      (carry_w[c]),
                    .byte_o       (byte_w[c]),
                    .match_o      (match_w[c]),
                    .hit_o        (hit_w[c])
                );
            end else begin : g_rest
                kmp_cell u_cell (
                    .aclk         (aclk),
                    .aresetn      (aresetn),
                    .ctrl         (ctrl),
                    .head_i       (1'b0),
                    .in_use_i     (use_w[c]),
                    .byte_prev_i  (byte_w[c - 1]),
                    .match_prev_i (match_w[c - 1]),
                    .carry_i      (carry_w[c]),
                    .byte_o       (byte_w[c]),
                    .match_o      (match_w[c]),
                    .hit_o        (hit_w[c])
                );
            end
        end
    endgenerate

    // whole pattern ends at this text byte
    assign found_o = hit_w[0];

endmodule
